>>> design/swfd_pkg.sv
// ----------------------------------------------------------------------------
// swfd_pkg
// Shared constants and types of the sync word frame deserializer.
// ----------------------------------------------------------------------------
package swfd_pkg;

    localparam int WORDS_PER_FRAME = 12;
    localparam int FRAME_BYTES     = 2 * WORDS_PER_FRAME;
    localparam int POS_W           = $clog2(FRAME_BYTES);
    localparam int ADDR_W          = POS_W - 1;
    localparam int BYTE_W          = 8;
    localparam int WORD_W          = 16;
    localparam int IDX_W           = 4;
    localparam int ERR_W           = 16;
    localparam int TDATA_BITS      = IDX_W + WORD_W + ERR_W;
    localparam int TDATA_W         = ((TDATA_BITS + 7) / 8) * 8;

    localparam logic [WORD_W-1:0] HEADER_RESET = 16'hAA55;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } t_wr_req;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

endpackage

>>> design/sync_word_frame_deserializer_core.sv
// ----------------------------------------------------------------------------
// sync_word_frame_deserializer_core
// Sync word framed byte-stream to word-stream receiver.
//
// Input stream: one received byte per request on the slave side. Every byte
// is shifted into a 16-bit header register; a match with the configured
// header word (i_cfg_we / i_cfg_wdata, reset 0xAA55) opens a frame. Frame
// bytes are packed in pairs into a 12 x 16-bit frame RAM. A header seen
// inside a frame bumps a wrapping 16-bit resync error count.
// Output stream: the byte that completes a frame triggers 12 word requests,
// index 0 first, tlast on the final one, each with the error count.
// Throughput: one byte per cycle while no frame is being read out. After a
// frame-ending byte the input is held off during readout, one frame RAM read
// per word; the byte sets the busy flag, then the first read sets valid.
// Receiver stall: readout pauses, the pending word holds, and the input
// stays held off until the last read has been issued.
// Reset: header register, frame state and error count clear; the header
// word returns to 0xAA55. Frame RAM contents are not cleared.
// ----------------------------------------------------------------------------
module sync_word_frame_deserializer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [swfd_pkg::WORD_W-1:0]   i_cfg_wdata,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [swfd_pkg::BYTE_W-1:0]   i_s_axis_tdata,   // rx_byte
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // word_index[3:0], word_value[19:4], resync_errors[35:20], zero pad
    output logic [swfd_pkg::TDATA_W-1:0]  o_m_axis_tdata,
    output logic                          o_m_axis_tlast    // last_word
);

    swfd_pkg::t_wr_req            wr;
    swfd_pkg::t_rd_req            rd;
    logic                         accept;
    logic                         done;
    logic                         busy;
    logic [swfd_pkg::ERR_W-1:0]   err;
    logic [swfd_pkg::WORD_W-1:0]  rdata;
    logic [swfd_pkg::IDX_W-1:0]   out_idx;
    logic [swfd_pkg::ERR_W-1:0]   out_err;

    assign o_s_axis_tready = !busy;
    assign accept          = i_s_axis_tvalid && !busy;

    swfd_fill u_fill (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_byte      (i_s_axis_tdata),
        .o_wr        (wr),
        .o_done      (done),
        .o_err       (err)
    );

    swfd_ram #(
        .WIDTH (swfd_pkg::WORD_W),
        .DEPTH (swfd_pkg::WORDS_PER_FRAME)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr.we),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_re    (rd.re),
        .i_raddr (rd.addr),
        .o_rdata (rdata)
    );

    swfd_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (done),
        .i_err       (err),
        .i_out_ready (i_m_axis_tready),
        .o_rd        (rd),
        .o_busy      (busy),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_idx   (out_idx),
        .o_out_last  (o_m_axis_tlast),
        .o_out_err   (out_err)
    );

    assign o_m_axis_tdata = {
        (swfd_pkg::TDATA_W - swfd_pkg::TDATA_BITS)'(0),
        out_err,
        rdata,
        out_idx
    };

endmodule

>>> design/swfd_ram.sv
// ----------------------------------------------------------------------------
// swfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 12
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/swfd_fill.sv
// ----------------------------------------------------------------------------
// swfd_fill
// Header matching, frame fill tracking and resync error counting.
// Pairs of bytes are packed into words and written to the frame RAM.
// ----------------------------------------------------------------------------
module swfd_fill (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [swfd_pkg::WORD_W-1:0]  i_cfg_wdata,
    input  logic                         i_accept,
    input  logic [swfd_pkg::BYTE_W-1:0]  i_byte,
    output swfd_pkg::t_wr_req            o_wr,
    output logic                         o_done,
    output logic [swfd_pkg::ERR_W-1:0]   o_err
);

    logic [swfd_pkg::WORD_W-1:0] r_header;
    logic [swfd_pkg::WORD_W-1:0] r_shift, n_shift;
    logic                        r_in_frame, n_in_frame;
    logic [swfd_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [swfd_pkg::ERR_W-1:0]  r_err, n_err;
    logic [swfd_pkg::BYTE_W-1:0] r_low, n_low;
    logic                        done;
    logic                        mid;

    always_comb begin
        n_shift    = r_shift;
        n_in_frame = r_in_frame;
        n_pos      = r_pos;
        n_err      = r_err;
        n_low      = r_low;
        done       = 1'b0;
        mid        = r_in_frame;
        o_wr.we    = 1'b0;
        o_wr.addr  = r_pos[swfd_pkg::POS_W-1:1];
        o_wr.data  = {i_byte, r_low};
        if (i_accept) begin
            n_shift = {r_shift[swfd_pkg::BYTE_W-1:0], i_byte};
            if (r_in_frame) begin
                if (r_pos[0]) begin
                    o_wr.we = 1'b1;
                end else begin
                    n_low = i_byte;
                end
                if (r_pos == swfd_pkg::POS_W'(swfd_pkg::FRAME_BYTES - 1)) begin
                    done       = 1'b1;
                    mid        = 1'b0;
                    n_in_frame = 1'b0;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            if (n_shift == r_header) begin
                if (mid) begin
                    n_err = r_err + 1'b1;
                end
                n_in_frame = 1'b1;
                n_pos      = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header   <= swfd_pkg::HEADER_RESET;
            r_shift    <= '0;
            r_in_frame <= 1'b0;
            r_pos      <= '0;
            r_err      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_header <= i_cfg_wdata;
            end
            r_shift    <= n_shift;
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_err      <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_low <= n_low;
    end

    assign o_done = done;
    assign o_err  = r_err;

endmodule

>>> design/swfd_emit.sv
// ----------------------------------------------------------------------------
// swfd_emit
// Frame readout sequencer: reads one word per cycle from the frame RAM unless
// the receiver stalls, and holds the result request until it is taken.
// ----------------------------------------------------------------------------
module swfd_emit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [swfd_pkg::ERR_W-1:0]   i_err,
    input  logic                         i_out_ready,
    output swfd_pkg::t_rd_req            o_rd,
    output logic                         o_busy,
    output logic                         o_out_valid,
    output logic [swfd_pkg::IDX_W-1:0]   o_out_idx,
    output logic                         o_out_last,
    output logic [swfd_pkg::ERR_W-1:0]   o_out_err
);

    logic                        r_busy, n_busy;
    logic [swfd_pkg::ADDR_W-1:0] r_k, n_k;
    logic                        r_vld, n_vld;
    logic [swfd_pkg::ADDR_W-1:0] r_idx;
    logic [swfd_pkg::ERR_W-1:0]  r_oerr;
    logic                        re;
    logic                        last_k;

    assign last_k = (r_k == swfd_pkg::ADDR_W'(swfd_pkg::WORDS_PER_FRAME - 1));
    assign re     = r_busy && (!r_vld || i_out_ready);

    always_comb begin
        n_busy = r_busy;
        n_k    = r_k;
        n_vld  = r_vld;
        if (i_start) begin
            n_busy = 1'b1;
            n_k    = '0;
        end
        if (re) begin
            n_vld = 1'b1;
            n_k   = r_k + 1'b1;
            if (last_k) begin
                n_busy = 1'b0;
            end
        end else if (i_out_ready) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
            r_vld  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_k    <= n_k;
            r_vld  <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (re) begin
            r_idx  <= r_k;
            r_oerr <= i_err;
        end
    end

    assign o_rd.re     = re;
    assign o_rd.addr   = r_k;
    assign o_busy      = r_busy;
    assign o_out_valid = r_vld;
    assign o_out_idx   = swfd_pkg::IDX_W'(r_idx);
    assign o_out_last  = (r_idx == swfd_pkg::ADDR_W'(swfd_pkg::WORDS_PER_FRAME - 1));
    assign o_out_err   = r_oerr;

endmodule
